>>> hw/rtl/mfq_pkg.sv
// Package with the shared types and constants of the multilevel feedback queue scheduler.
`default_nettype none

package mfq_pkg;

  localparam int KIND_W  = 3;
  localparam int PID_W   = 6;
  localparam int TICK_W  = 32;
  localparam int LVL_W   = 3;
  localparam int STAT_W  = 2;
  localparam int LIMIT_W = 16;

  localparam logic [LIMIT_W-1:0] AGING_RESET = 16'd30;

  localparam logic [KIND_W-1:0] KIND_ADMIT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAKE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PICK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RETURN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP       = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    OP_ADMIT,
    OP_WAKE,
    OP_PICK,
    OP_RETURN,
    OP_REMOVE,
    OP_IGNORE,
    OP_BAD_PID
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PID_W-1:0]  pid;
    logic [TICK_W-1:0] now;
    logic              demote;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_SELECT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    SCAN_AGE,
    SCAN_HEAD,
    SCAN_DROP_PID
  } scan_e;

endpackage

`default_nettype wire

>>> hw/rtl/mfq_evt_if.sv
// Interface of the event input channel.
`default_nettype none

interface mfq_evt_if;
  import mfq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PID_W-1:0]    process_id;
  logic [TICK_W-1:0]   now_tick;
  logic                demote;

  modport source (output valid, output kind, output process_id, output now_tick,
                  output demote, input ready);
  modport sink (input valid, input kind, input process_id, input now_tick,
                input demote, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mfq_res_if.sv
// Interface of the result output channel.
`default_nettype none

interface mfq_res_if;
  import mfq_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [PID_W-1:0]   chosen_pid;
  logic [LVL_W-1:0]   chosen_level;

  modport source (output valid, output status, output chosen_pid, output chosen_level,
                  input ready);
  modport sink (input valid, input status, input chosen_pid, input chosen_level,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mfq_cfg_if.sv
// Interface of the aging limit configuration write channel.
`default_nettype none

interface mfq_cfg_if;
  import mfq_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mfq_front.sv
// Front end that accepts event beats and classifies them into commands.
`default_nettype none

module mfq_front #(
  parameter int NUM_PROCS = 64
) (
  mfq_evt_if.sink         evt_i,
  input  logic            full_i,
  output logic            push_o,
  output mfq_pkg::cmd_t   cmd_o
);
  import mfq_pkg::*;

  logic bad_pid;

  assign bad_pid     = (32'(evt_i.process_id) >= 32'(NUM_PROCS));
  assign evt_i.ready = !full_i;
  assign push_o      = evt_i.valid && !full_i;

  always_comb begin
    cmd_o.pid    = evt_i.process_id;
    cmd_o.now    = evt_i.now_tick;
    cmd_o.demote = evt_i.demote;
    case (evt_i.kind)
      KIND_PICK:   cmd_o.op = OP_PICK;
      KIND_ADMIT:  cmd_o.op = bad_pid ? OP_BAD_PID : OP_ADMIT;
      KIND_WAKE:   cmd_o.op = bad_pid ? OP_BAD_PID : OP_WAKE;
      KIND_RETURN: cmd_o.op = bad_pid ? OP_BAD_PID : OP_RETURN;
      KIND_REMOVE: cmd_o.op = bad_pid ? OP_BAD_PID : OP_REMOVE;
      default:     cmd_o.op = OP_IGNORE;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/mfq_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module mfq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfq_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output mfq_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import mfq_pkg::*;

  cmd_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? !wptr_q : wptr_q;
    rptr_d  = pop_i ? !rptr_q : rptr_q;
    count_d = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mfq_back.sv
// Back end that keeps the level queues and carries out each command.
`default_nettype none

module mfq_back #(
  parameter int NUM_PROCS  = 64,
  parameter int NUM_LEVELS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mfq_pkg::LIMIT_W-1:0]   aging_limit_i,
  input  mfq_pkg::cmd_t                 cmd_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  mfq_res_if.source                     res_o
);
  import mfq_pkg::*;

  localparam int SW    = $clog2(NUM_PROCS);
  localparam int OW    = $clog2(NUM_PROCS + 1);
  localparam int LW    = $clog2(NUM_LEVELS);
  localparam int AW    = LW + SW;
  localparam int DEPTH = NUM_LEVELS * (2 ** SW);
  localparam int NPID  = 2 ** PID_W;
  localparam logic [LW-1:0] TOP_LVL = LW'(NUM_LEVELS - 1);

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  scan_e             mode_q, mode_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [OW-1:0]     rd_q, rd_d;
  logic [OW-1:0]     wr_q, wr_d;
  logic [OW-1:0]     jdx_q, jdx_d;
  logic              pend_q, pend_d;
  logic [OW-1:0]     occ_q [NUM_LEVELS];
  logic [OW-1:0]     occ_d [NUM_LEVELS];
  logic [NPID-1:0]   queued_q, queued_d;
  logic [NPID-1:0]   plvl_vld_q, plvl_vld_d;

  logic [STAT_W-1:0] rs_status_q, rs_status_d;
  logic [PID_W-1:0]  rs_pid_q, rs_pid_d;
  logic [LW-1:0]     rs_lvl_q, rs_lvl_d;

  logic              out_vld_q;
  logic [STAT_W-1:0] out_status_q;
  logic [PID_W-1:0]  out_pid_q;
  logic [LVL_W-1:0]  out_lvl_q;

  logic [PID_W-1:0]  pid_mem [DEPTH];
  logic [TICK_W-1:0] stamp_mem [DEPTH];
  logic              slot_we, slot_ren;
  logic [AW-1:0]     slot_waddr, slot_raddr;
  logic [PID_W-1:0]  slot_wpid, rd_pid_q;
  logic [TICK_W-1:0] slot_wstamp, rd_stamp_q;

  logic [LW-1:0]     plvl_mem [NPID];
  logic              plvl_we;
  logic [PID_W-1:0]  plvl_waddr;
  logic [LW-1:0]     plvl_wdata, plvl_rd_q, plvl_cur;
  logic              plvl_hit_q;

  logic              scan_end, drop, dup, sel_found, out_free;
  logic [LW-1:0]     sel_lvl, add_lvl, lvl_up;
  logic [TICK_W-1:0] age;

  assign plvl_cur = plvl_hit_q ? plvl_rd_q : '0;
  assign scan_end = !pend_q && (rd_q >= occ_q[lvl_q]);
  assign dup      = queued_q[cmd_q.pid];
  assign lvl_up   = lvl_q - LW'(1);
  assign age      = cmd_q.now - rd_stamp_q;
  assign out_free = !out_vld_q || res_o.ready;

  always_comb begin
    add_lvl = '0;
    if (cmd_q.op == OP_WAKE || cmd_q.op == OP_RETURN) begin
      add_lvl = plvl_cur;
    end
    if (cmd_q.op == OP_RETURN && cmd_q.demote && plvl_cur != TOP_LVL) begin
      add_lvl = plvl_cur + LW'(1);
    end
  end

  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (occ_q[l] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = LW'(l);
      end
    end
  end

  always_comb begin
    case (mode_q)
      SCAN_AGE:      drop = (age > 32'(aging_limit_i));
      SCAN_HEAD:     drop = (jdx_q == '0);
      SCAN_DROP_PID: drop = (rd_pid_q == cmd_q.pid);
      default:       drop = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        case (cmd_q.op)
          OP_PICK:   state_d = S_SCAN;
          OP_REMOVE: state_d = dup ? S_SCAN : S_DONE;
          default:   state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (scan_end) begin
          if (mode_q == SCAN_AGE && lvl_q != TOP_LVL) begin
            state_d = S_SCAN;
          end else if (mode_q == SCAN_AGE) begin
            state_d = S_SELECT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SELECT: begin
        state_d = sel_found ? S_SCAN : S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    mode_d      = mode_q;
    lvl_d       = lvl_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    jdx_d       = jdx_q;
    pend_d      = pend_q;
    occ_d       = occ_q;
    queued_d    = queued_q;
    plvl_vld_d  = plvl_vld_q;
    rs_status_d = rs_status_q;
    rs_pid_d    = rs_pid_q;
    rs_lvl_d    = rs_lvl_q;
    pop_o       = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = '0;
    slot_wpid   = rd_pid_q;
    slot_wstamp = rd_stamp_q;
    slot_ren    = 1'b0;
    slot_raddr  = {lvl_q, rd_q[SW-1:0]};
    plvl_we     = 1'b0;
    plvl_waddr  = rd_pid_q;
    plvl_wdata  = '0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
        end
      end
      S_LOOKUP: begin
        rs_status_d = STAT_OK;
        rs_pid_d    = cmd_q.pid;
        rs_lvl_d    = '0;
        rd_d        = '0;
        wr_d        = '0;
        pend_d      = 1'b0;
        case (cmd_q.op)
          OP_ADMIT, OP_WAKE, OP_RETURN: begin
            if (dup) begin
              rs_status_d = STAT_DUP;
            end else begin
              slot_we                 = 1'b1;
              slot_waddr              = {add_lvl, occ_q[add_lvl][SW-1:0]};
              slot_wpid               = cmd_q.pid;
              slot_wstamp             = cmd_q.now;
              occ_d[add_lvl]          = occ_q[add_lvl] + OW'(1);
              queued_d[cmd_q.pid]     = 1'b1;
              plvl_we                 = 1'b1;
              plvl_waddr              = cmd_q.pid;
              plvl_wdata              = add_lvl;
              plvl_vld_d[cmd_q.pid]   = 1'b1;
              rs_lvl_d                = add_lvl;
            end
          end
          OP_PICK: begin
            rs_pid_d = '0;
            mode_d   = SCAN_AGE;
            lvl_d    = LW'(1);
          end
          OP_REMOVE: begin
            if (dup) begin
              mode_d   = SCAN_DROP_PID;
              lvl_d    = plvl_cur;
              rs_lvl_d = plvl_cur;
            end else begin
              rs_status_d = STAT_NOT_FOUND;
            end
          end
          OP_BAD_PID: rs_status_d = STAT_NOT_FOUND;
          default:    rs_status_d = STAT_OK;
        endcase
      end
      S_SCAN: begin
        if (pend_q) begin
          if (drop) begin
            case (mode_q)
              SCAN_AGE: begin
                slot_we              = 1'b1;
                slot_waddr           = {lvl_up, occ_q[lvl_up][SW-1:0]};
                slot_wstamp          = cmd_q.now;
                occ_d[lvl_up]        = occ_q[lvl_up] + OW'(1);
                plvl_we              = 1'b1;
                plvl_wdata           = lvl_up;
                plvl_vld_d[rd_pid_q] = 1'b1;
              end
              SCAN_HEAD: begin
                rs_pid_d           = rd_pid_q;
                queued_d[rd_pid_q] = 1'b0;
              end
              default: begin
                queued_d[rd_pid_q]   = 1'b0;
                plvl_we              = 1'b1;
                plvl_wdata           = '0;
                plvl_vld_d[rd_pid_q] = 1'b1;
              end
            endcase
          end else begin
            slot_we    = 1'b1;
            slot_waddr = {lvl_q, wr_q[SW-1:0]};
            wr_d       = wr_q + OW'(1);
          end
        end
        if (rd_q < occ_q[lvl_q]) begin
          slot_ren = 1'b1;
          rd_d     = rd_q + OW'(1);
          jdx_d    = rd_q;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (scan_end) begin
          occ_d[lvl_q] = wr_q;
          if (mode_q == SCAN_AGE && lvl_q != TOP_LVL) begin
            lvl_d = lvl_q + LW'(1);
            rd_d  = '0;
            wr_d  = '0;
          end
        end
      end
      S_SELECT: begin
        rd_d   = '0;
        wr_d   = '0;
        pend_d = 1'b0;
        if (sel_found) begin
          mode_d      = SCAN_HEAD;
          lvl_d       = sel_lvl;
          rs_status_d = STAT_OK;
          rs_lvl_d    = sel_lvl;
        end else begin
          rs_status_d = STAT_EMPTY;
          rs_pid_d    = '0;
          rs_lvl_d    = '0;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      queued_q   <= '0;
      plvl_vld_q <= '0;
      out_vld_q  <= 1'b0;
      pend_q     <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        occ_q[l] <= '0;
      end
    end else begin
      state_q    <= state_d;
      queued_q   <= queued_d;
      plvl_vld_q <= plvl_vld_d;
      pend_q     <= pend_d;
      occ_q      <= occ_d;
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    mode_q      <= mode_d;
    lvl_q       <= lvl_d;
    rd_q        <= rd_d;
    wr_q        <= wr_d;
    jdx_q       <= jdx_d;
    rs_status_q <= rs_status_d;
    rs_pid_q    <= rs_pid_d;
    rs_lvl_q    <= rs_lvl_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= rs_status_q;
      out_pid_q    <= rs_pid_q;
      out_lvl_q    <= LVL_W'(rs_lvl_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      pid_mem[slot_waddr]   <= slot_wpid;
      stamp_mem[slot_waddr] <= slot_wstamp;
    end
    if (slot_ren) begin
      rd_pid_q   <= pid_mem[slot_raddr];
      rd_stamp_q <= stamp_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (plvl_we) begin
      plvl_mem[plvl_waddr] <= plvl_wdata;
    end
    plvl_rd_q  <= plvl_mem[cmd_i.pid];
    plvl_hit_q <= plvl_vld_q[cmd_i.pid];
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.status       = out_status_q;
  assign res_o.chosen_pid   = out_pid_q;
  assign res_o.chosen_level = out_lvl_q;

endmodule

`default_nettype wire

>>> hw/rtl/multilevel_feedback_queue_scheduler_top.sv
// Top level of the multilevel feedback queue scheduler.
// Each event beat yields exactly one result beat. Admit, wake, return, unknown kinds and
// refused events go from the lookup state straight to the done state in the back end. A remove
// of a queued process walks every entry of the level that holds the process. A pick walks
// each of levels 1 and up to age their entries, then selects a level and, when a process is
// ready, walks the level it picks from. The time that these walks take is set by the slot
// memory, which the back end walks one entry per cycle, reading one entry and writing back
// another, to age and compact the levels. A stalled result beat holds the back end until it
// is taken. A two-beat command queue lets new events be taken while one is still at work.
`default_nettype none

module multilevel_feedback_queue_scheduler_top #(
  parameter int NUM_PROCS  = 64,
  parameter int NUM_LEVELS = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mfq_evt_if.sink   evt_i,
  mfq_cfg_if.sink   cfg_i,
  mfq_res_if.source res_o
);
  import mfq_pkg::*;

  logic [LIMIT_W-1:0] aging_limit_q;
  logic               push, full, pop, empty;
  cmd_t               front_cmd, back_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_limit_q <= AGING_RESET;
    end else if (cfg_i.valid) begin
      aging_limit_q <= cfg_i.data;
    end
  end

  mfq_front #(
    .NUM_PROCS(NUM_PROCS)
  ) u_front (
    .evt_i  (evt_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  mfq_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (back_cmd),
    .empty_o (empty)
  );

  mfq_back #(
    .NUM_PROCS  (NUM_PROCS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .aging_limit_i (aging_limit_q),
    .cmd_i         (back_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .res_o         (res_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status == STAT_EMPTY |->
      res_o.chosen_pid == '0 && res_o.chosen_level == '0)
    else $error("Empty pick must report process zero at level zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != STAT_OK |-> res_o.chosen_level == '0)
    else $error("A refused event must report level zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> 32'(res_o.chosen_level) < 32'(NUM_LEVELS))
    else $error("Reported level is beyond the last level.");

endmodule

`default_nettype wire

>>> bench/tb_multilevel_feedback_queue_scheduler_top.sv
// Self-checking testbench of the multilevel feedback queue scheduler top level.
`default_nettype none

class mfq_scoreboard;
  typedef struct packed {
    logic [mfq_pkg::PID_W-1:0]  pid;
    logic [mfq_pkg::TICK_W-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic [mfq_pkg::STAT_W-1:0] status;
    logic [mfq_pkg::PID_W-1:0]  pid;
    logic [mfq_pkg::LVL_W-1:0]  level;
  } verdict_t;

  slot_t                      level_q[5][$];
  logic [mfq_pkg::LVL_W-1:0]  proc_lvl[64];
  logic [mfq_pkg::LIMIT_W-1:0] aging_limit;
  verdict_t                   verdicts[$];
  int                         errors;

  function new();
    aging_limit = mfq_pkg::AGING_RESET;
    errors = 0;
    for (int p = 0; p < 64; p++) proc_lvl[p] = '0;
  endfunction

  function int pending();
    return verdicts.size();
  endfunction

  function bit is_queued(logic [5:0] pid);
    for (int l = 0; l < 5; l++)
      foreach (level_q[l][i]) if (level_q[l][i].pid == pid) return 1'b1;
    return 1'b0;
  endfunction

  function void note_event(logic [2:0] kind, logic [5:0] pid, logic [31:0] now, logic dem);
    verdict_t v;
    int lvl;
    int j;
    slot_t s;
    v.status = mfq_pkg::STAT_OK;
    v.pid = pid;
    v.level = '0;
    if (kind == mfq_pkg::KIND_PICK) begin
      for (int l = 1; l < 5; l++) begin
        j = 0;
        while (j < level_q[l].size()) begin
          if (now - level_q[l][j].stamp > {16'd0, aging_limit}) begin
            s.pid = level_q[l][j].pid;
            s.stamp = now;
            level_q[l].delete(j);
            level_q[l-1].push_back(s);
            proc_lvl[s.pid] = 3'(l - 1);
          end else begin
            j++;
          end
        end
      end
      v.status = mfq_pkg::STAT_EMPTY;
      v.pid = '0;
      for (int l = 0; l < 5; l++) begin
        if (level_q[l].size() > 0) begin
          s = level_q[l].pop_front();
          v.status = mfq_pkg::STAT_OK;
          v.pid = s.pid;
          v.level = 3'(l);
          break;
        end
      end
    end else if (kind == mfq_pkg::KIND_REMOVE) begin
      lvl = int'(proc_lvl[pid]);
      v.status = mfq_pkg::STAT_NOT_FOUND;
      foreach (level_q[lvl][i]) begin
        if (level_q[lvl][i].pid == pid && v.status != mfq_pkg::STAT_OK) begin
          level_q[lvl].delete(i);
          proc_lvl[pid] = '0;
          v.status = mfq_pkg::STAT_OK;
          v.level = 3'(lvl);
          break;
        end
      end
    end else if (kind <= mfq_pkg::KIND_RETURN) begin
      if (is_queued(pid)) begin
        v.status = mfq_pkg::STAT_DUP;
      end else begin
        lvl = (kind == mfq_pkg::KIND_ADMIT) ? 0 : int'(proc_lvl[pid]);
        if (kind == mfq_pkg::KIND_RETURN && dem && lvl < 4) lvl++;
        s.pid = pid;
        s.stamp = now;
        level_q[lvl].push_back(s);
        proc_lvl[pid] = 3'(lvl);
        v.level = 3'(lvl);
      end
    end
    verdicts.push_back(v);
  endfunction

  function void check_result(logic [1:0] st, logic [5:0] cpid, logic [2:0] clvl);
    verdict_t v;
    if (verdicts.size() == 0) begin
      $display("%0t: unexpected result beat status=%0d pid=%0d level=%0d",
               $time, st, cpid, clvl);
      errors++;
      return;
    end
    v = verdicts.pop_front();
    if (st !== v.status) begin
      $display("%0t: status expected %0d actual %0d", $time, v.status, st);
      errors++;
    end
    if (cpid !== v.pid) begin
      $display("%0t: chosen_pid expected %0d actual %0d", $time, v.pid, cpid);
      errors++;
    end
    if (clvl !== v.level) begin
      $display("%0t: chosen_level expected %0d actual %0d", $time, v.level, clvl);
      errors++;
    end
  endfunction
endclass

module tb_multilevel_feedback_queue_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mfq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NOOP_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NOOP_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOOP_HI  = 3'd7;

  logic clk_i;
  logic rst_ni;
  bit   calm;
  bit   hold_req;
  int   hold_left;
  logic [31:0] tick;
  mfq_scoreboard sb;

  mfq_evt_if evt();
  mfq_cfg_if cfg();
  mfq_res_if res();

  multilevel_feedback_queue_scheduler_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .cfg_i (cfg),
    .res_o (res)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb_multilevel_feedback_queue_scheduler_top NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) sb.check_result(res.status, res.chosen_pid,
                                                          res.chosen_level);
  end

  initial begin
    res.ready = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 600;
        res.ready <= 1'b0;
      end else begin
        res.ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  task automatic send_event(logic [2:0] kind, logic [5:0] pid, logic [31:0] now, logic dem);
    if (!calm && $urandom_range(0, 99) < 16) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    evt.valid      <= 1'b1;
    evt.kind       <= kind;
    evt.process_id <= pid;
    evt.now_tick   <= now;
    evt.demote     <= dem;
    do @(posedge clk_i); while (!evt.ready);
    sb.note_event(kind, pid, now, dem);
  endtask

  task automatic drain();
    evt.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.aging_limit = value;
  endtask

  task automatic random_event(int pid_span);
    logic [2:0] kind;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) kind = KIND_ADMIT;
    else if (r < 35) kind = KIND_WAKE;
    else if (r < 62) kind = KIND_PICK;
    else if (r < 82) kind = KIND_RETURN;
    else if (r < 95) kind = KIND_REMOVE;
    else kind = 3'($urandom_range(KIND_NOOP_LO, KIND_NOOP_HI));
    if ($urandom_range(0, 99) < 3) tick = $urandom;
    else tick = tick + $urandom_range(0, 25);
    send_event(kind, 6'($urandom_range(0, pid_span)), tick, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    evt.valid = 1'b0;
    evt.kind = '0;
    evt.process_id = '0;
    evt.now_tick = '0;
    evt.demote = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(KIND_ADMIT, 6'd0, 32'd0, 1'b0);
    send_event(KIND_ADMIT, 6'd63, 32'd1, 1'b1);
    send_event(KIND_ADMIT, 6'd0, 32'd2, 1'b0);
    send_event(KIND_WAKE, 6'd63, 32'd3, 1'b0);
    send_event(KIND_RETURN, 6'd63, 32'd3, 1'b1);
    send_event(KIND_PICK, 6'd5, 32'd4, 1'b0);
    for (int k = 0; k < 5; k++) begin
      send_event(KIND_RETURN, 6'd0, 32'd5, 1'b1);
      send_event(KIND_PICK, 6'd0, 32'd5, 1'b0);
    end
    send_event(KIND_REMOVE, 6'd63, 32'd6, 1'b0);
    send_event(KIND_REMOVE, 6'd63, 32'd6, 1'b0);
    send_event(KIND_WAKE, 6'd0, 32'hFFFF_FFF0, 1'b0);
    send_event(KIND_ADMIT, 6'd42, 32'hFFFF_FFFF, 1'b0);
    send_event(KIND_RETURN, 6'd21, 32'hFFFF_FFFF, 1'b1);
    send_event(KIND_PICK, 6'd0, 32'd100, 1'b0);
    send_event(KIND_PICK, 6'd0, 32'd100, 1'b0);
    send_event(KIND_PICK, 6'd0, 32'd100, 1'b0);
    send_event(KIND_PICK, 6'd0, 32'd100, 1'b0);
    send_event(KIND_NOOP_LO, 6'd9, 32'd101, 1'b1);
    send_event(KIND_NOOP_MID, 6'd10, 32'd101, 1'b0);
    send_event(KIND_NOOP_HI, 6'd11, 32'd101, 1'b1);

    tick = 32'd200;
    for (int n = 0; n < 175; n++) begin
      if (n == 60) hold_req = 1'b1;
      random_event(15);
    end
    write_limit(16'd0);
    for (int n = 0; n < 175; n++) begin
      calm = (n >= 50 && n < 130);
      if (n == 140) drain();
      random_event(63);
    end
    calm = 1'b0;
    write_limit(16'hFFFF);
    for (int n = 0; n < 175; n++) random_event(31);
    write_limit(16'($urandom_range(1, 60)));
    for (int n = 0; n < 175; n++) random_event(15);
    write_limit(16'd30);
    for (int n = 0; n < 20; n++) random_event(7);

    evt.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_multilevel_feedback_queue_scheduler_top OK");
    end else begin
      $display("tb_multilevel_feedback_queue_scheduler_top NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> sim.f
hw/rtl/mfq_pkg.sv
hw/rtl/mfq_evt_if.sv
hw/rtl/mfq_res_if.sv
hw/rtl/mfq_cfg_if.sv
hw/rtl/mfq_front.sv
hw/rtl/mfq_cmd_fifo.sv
hw/rtl/mfq_back.sv
hw/rtl/multilevel_feedback_queue_scheduler_top.sv
bench/tb_multilevel_feedback_queue_scheduler_top.sv
